FILE: hdl/lcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lcp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpW      = 16;
  localparam int unsigned MaxBytes = 3;
  localparam int unsigned CntW     = 2;

  localparam logic [ByteW-1:0] AsciiLimit   = 8'h80;
  localparam logic [ByteW-1:0] Cp1251TabEnd = 8'hBF;
  localparam logic [ByteW-1:0] Cp1252TabEnd = 8'h9F;
  localparam logic [CpW-1:0]   Cp1251Offset = 16'h0410 - 16'h00C0;
  localparam logic [CpW-1:0]   TwoByteLimit = 16'h0800;
  localparam logic [ByteW-1:0] Lead2        = 8'b1100_0000;
  localparam logic [ByteW-1:0] Lead3        = 8'b1110_0000;
  localparam logic [ByteW-1:0] ContMark     = 8'b1000_0000;
  localparam logic [ByteW-1:0] SixBits      = 8'b0011_1111;

  localparam logic CodepageCp1251 = 1'b0;
  localparam logic CodepageCp1252 = 1'b1;

  localparam logic [CntW-1:0] CountOne   = 2'd1;
  localparam logic [CntW-1:0] CountTwo   = 2'd2;
  localparam logic [CntW-1:0] CountThree = 2'd3;

  // bytes[0] goes out first
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                count;
  } enc_t;

  function automatic logic [CpW-1:0] cp1251_high(input logic [5:0] idx);
    logic [CpW-1:0] cp;
    unique case (idx)
      6'd0:  cp = 16'h0402; 6'd1:  cp = 16'h0403; 6'd2:  cp = 16'h201A;
      6'd3:  cp = 16'h0453; 6'd4:  cp = 16'h201E; 6'd5:  cp = 16'h2026;
      6'd6:  cp = 16'h2020; 6'd7:  cp = 16'h2021; 6'd8:  cp = 16'h20AC;
      6'd9:  cp = 16'h2030; 6'd10: cp = 16'h0409; 6'd11: cp = 16'h2039;
      6'd12: cp = 16'h040A; 6'd13: cp = 16'h040C; 6'd14: cp = 16'h040B;
      6'd15: cp = 16'h040F; 6'd16: cp = 16'h0452; 6'd17: cp = 16'h2018;
      6'd18: cp = 16'h2019; 6'd19: cp = 16'h201C; 6'd20: cp = 16'h201D;
      6'd21: cp = 16'h2022; 6'd22: cp = 16'h2013; 6'd23: cp = 16'h2014;
      6'd24: cp = 16'h0098; 6'd25: cp = 16'h2122; 6'd26: cp = 16'h0459;
      6'd27: cp = 16'h203A; 6'd28: cp = 16'h045A; 6'd29: cp = 16'h045C;
      6'd30: cp = 16'h045B; 6'd31: cp = 16'h045F; 6'd32: cp = 16'h00A0;
      6'd33: cp = 16'h040E; 6'd34: cp = 16'h045E; 6'd35: cp = 16'h0408;
      6'd36: cp = 16'h00A4; 6'd37: cp = 16'h0490; 6'd38: cp = 16'h00A6;
      6'd39: cp = 16'h00A7; 6'd40: cp = 16'h0401; 6'd41: cp = 16'h00A9;
      6'd42: cp = 16'h0404; 6'd43: cp = 16'h00AB; 6'd44: cp = 16'h00AC;
      6'd45: cp = 16'h00AD; 6'd46: cp = 16'h00AE; 6'd47: cp = 16'h0407;
      6'd48: cp = 16'h00B0; 6'd49: cp = 16'h00B1; 6'd50: cp = 16'h0406;
      6'd51: cp = 16'h0456; 6'd52: cp = 16'h0491; 6'd53: cp = 16'h00B5;
      6'd54: cp = 16'h00B6; 6'd55: cp = 16'h00B7; 6'd56: cp = 16'h0451;
      6'd57: cp = 16'h2116; 6'd58: cp = 16'h0454; 6'd59: cp = 16'h00BB;
      6'd60: cp = 16'h0458; 6'd61: cp = 16'h0405; 6'd62: cp = 16'h0455;
      default: cp = 16'h0457;
    endcase
    return cp;
  endfunction

  function automatic logic [CpW-1:0] cp1252_high(input logic [4:0] idx);
    logic [CpW-1:0] cp;
    unique case (idx)
      5'd0:  cp = 16'h20AC; 5'd1:  cp = 16'h0081; 5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192; 5'd4:  cp = 16'h201E; 5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020; 5'd7:  cp = 16'h2021; 5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030; 5'd10: cp = 16'h0160; 5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152; 5'd13: cp = 16'h008D; 5'd14: cp = 16'h017D;
      5'd15: cp = 16'h008F; 5'd16: cp = 16'h0090; 5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019; 5'd19: cp = 16'h201C; 5'd20: cp = 16'h201D;
      5'd21: cp = 16'h2022; 5'd22: cp = 16'h2013; 5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC; 5'd25: cp = 16'h2122; 5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A; 5'd28: cp = 16'h0153; 5'd29: cp = 16'h009D;
      5'd30: cp = 16'h017E;
      default: cp = 16'h0178;
    endcase
    return cp;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lcp_encode.sv
`timescale 1ns / 1ps
`default_nettype none
module lcp_encode (
  input  wire logic                     codepage_i,
  input  wire logic [lcp_pkg::ByteW-1:0] byte_i,
  output lcp_pkg::enc_t                 enc_o
);

  logic [lcp_pkg::CpW-1:0] cp;

  always_comb begin
    if (codepage_i == lcp_pkg::CodepageCp1251) begin
      if (byte_i <= lcp_pkg::Cp1251TabEnd) begin
        cp = lcp_pkg::cp1251_high(byte_i[5:0]);
      end else begin
        cp = {8'h00, byte_i} + lcp_pkg::Cp1251Offset;
      end
    end else begin
      if (byte_i <= lcp_pkg::Cp1252TabEnd) begin
        cp = lcp_pkg::cp1252_high(byte_i[4:0]);
      end else begin
        cp = {8'h00, byte_i};
      end
    end
  end

  always_comb begin
    enc_o.bytes = '0;
    if (byte_i < lcp_pkg::AsciiLimit) begin
      enc_o.bytes[0] = byte_i;
      enc_o.count    = lcp_pkg::CountOne;
    end else if (cp < lcp_pkg::TwoByteLimit) begin
      enc_o.bytes[0] = lcp_pkg::Lead2 | {3'b000, cp[10:6]};
      enc_o.bytes[1] = lcp_pkg::ContMark | ({2'b00, cp[5:0]} & lcp_pkg::SixBits);
      enc_o.count    = lcp_pkg::CountTwo;
    end else begin
      enc_o.bytes[0] = lcp_pkg::Lead3 | {4'h0, cp[15:12]};
      enc_o.bytes[1] = lcp_pkg::ContMark | {2'b00, cp[11:6]};
      enc_o.bytes[2] = lcp_pkg::ContMark | {2'b00, cp[5:0]};
      enc_o.count    = lcp_pkg::CountThree;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/legacy_codepage_to_utf8.sv
`timescale 1ns / 1ps
`default_nettype none
// Windows-1251 / Windows-1252 to UTF-8 transcoder. Each input item is one
// legacy byte; it leaves as one to three UTF-8 bytes, one per cycle while
// out_stall_i is low, with last_of_char_o set on the final one. The byte is
// mapped and encoded in the cycle it is accepted and held in a one-item
// buffer ahead of the output serializer, so a new byte is taken while the
// previous one is still being sent. Sustained rate is set by the serializer,
// which sends all of an item's UTF-8 bytes (1 for ASCII, 2 or 3 otherwise)
// before it takes the next item. The input stalls only while the buffer is
// full and the serializer is busy and not handing off its final byte in that cycle.
// cfg_wr_en_i writes the codepage register codepage_q (0 = 1251, 1 = 1252); reset selects 1251.
module legacy_codepage_to_utf8 (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_wr_en_i,
  input  wire logic                      cfg_wr_data_i,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [lcp_pkg::ByteW-1:0] legacy_byte_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic [lcp_pkg::ByteW-1:0] utf8_byte_o,
  output      logic                      last_of_char_o
);

  logic          codepage_q;
  lcp_pkg::enc_t enc;

  logic          slot_valid_q, slot_valid_d;
  lcp_pkg::enc_t slot_q, slot_d;

  logic                                          ser_valid_q, ser_valid_d;
  logic [lcp_pkg::MaxBytes-1:0][lcp_pkg::ByteW-1:0] ser_bytes_q, ser_bytes_d;
  logic [lcp_pkg::CntW-1:0]                      ser_rem_q, ser_rem_d;

  logic in_accept, out_accept, ser_last, ser_free, move;

  lcp_encode u_encode (
    .codepage_i (codepage_q),
    .byte_i     (legacy_byte_i),
    .enc_o      (enc)
  );

  assign ser_last       = (ser_rem_q == lcp_pkg::CountOne);
  assign out_valid_o    = ser_valid_q;
  assign utf8_byte_o    = ser_bytes_q[0];
  assign last_of_char_o = ser_last;
  assign out_accept     = ser_valid_q && !out_stall_i;
  assign ser_free       = !ser_valid_q || (out_accept && ser_last);
  assign move           = slot_valid_q && ser_free;

  assign in_stall_o = slot_valid_q && !ser_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    slot_valid_d = slot_valid_q;
    slot_d       = slot_q;
    if (in_accept) begin
      slot_valid_d = 1'b1;
      slot_d       = enc;
    end else if (move) begin
      slot_valid_d = 1'b0;
    end
  end

  always_comb begin
    ser_valid_d = ser_valid_q;
    ser_bytes_d = ser_bytes_q;
    ser_rem_d   = ser_rem_q;
    if (move) begin
      ser_valid_d = 1'b1;
      ser_bytes_d = slot_q.bytes;
      ser_rem_d   = slot_q.count;
    end else if (out_accept) begin
      if (ser_last) begin
        ser_valid_d = 1'b0;
      end
      ser_bytes_d = {{lcp_pkg::ByteW{1'b0}}, ser_bytes_q[lcp_pkg::MaxBytes-1:1]};
      ser_rem_d   = ser_rem_q - lcp_pkg::CountOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codepage_q   <= lcp_pkg::CodepageCp1251;
      slot_valid_q <= 1'b0;
      ser_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        codepage_q <= cfg_wr_data_i;
      end
      slot_valid_q <= slot_valid_d;
      ser_valid_q  <= ser_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    ser_bytes_q <= ser_bytes_d;
    ser_rem_q   <= ser_rem_d;
  end

endmodule
`default_nettype wire
